### hw/rtl/assert_macros.svh
// assertion macros used by fourier_waveform_synth_unit
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define FWS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent on the next clock edge
`define FWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fws_pkg.sv
// package for the fourier waveform synthesizer: widths, coefficients, table function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fws_pkg;

    localparam int HARMONICS_DEF  = 8;
    localparam int PHASE_BITS_DEF = 16;
    localparam int TABLE_BITS_DEF = 10;
    localparam int MAX_HARM       = 16;

    localparam int PHASE_W  = 16;
    localparam int FLOW_W   = 32;
    localparam int SCALE_W  = 20;
    localparam int TVAL_W   = 17;
    localparam int COEF_W   = 25;
    localparam int PROD_W   = 42;
    localparam int HSUM_W   = 43;
    localparam int GSUM_W   = 45;
    localparam int ACC_W    = 48;
    localparam int ACC_LO_W = 24;
    localparam int PLO_W    = ACC_LO_W + SCALE_W;
    localparam int PHI_W    = ACC_W - ACC_LO_W + SCALE_W + 1;
    localparam int SPROD_W  = ACC_W + SCALE_W;
    localparam int RND_SH   = 32;
    localparam int RND_W    = SPROD_W - RND_SH;
    localparam int GRP_SIZE = 4;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd65536;

    localparam logic signed [COEF_W-1:0] DC_TERM = 25'sd6828851;
    localparam logic signed [ACC_W-1:0]  DC_Q32  = ACC_W'(DC_TERM) <<< 16;

    localparam logic signed [COEF_W-1:0] COS_COEF [MAX_HARM] = '{
        25'sd7798784, -25'sd1165885, -25'sd3050045, -25'sd1806172,
        -25'sd2127299, -25'sd1270088, -25'sd524419, -25'sd1040056,
        25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0
    };
    localparam logic signed [COEF_W-1:0] SIN_COEF [MAX_HARM] = '{
        25'sd9351987, 25'sd8500019, 25'sd3264348, 25'sd1804861,
        25'sd1074790, -25'sd157876, 25'sd389415, 25'sd220987,
        25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0, 25'sd0
    };

    localparam logic [SPROD_W-1:0] RND_BIAS_POS = SPROD_W'(64'h0000_0000_8000_0000);
    localparam logic [SPROD_W-1:0] RND_BIAS_NEG = SPROD_W'(64'h0000_0000_7FFF_FFFF);

    localparam logic [FLOW_W-1:0] FLOW_MAX = 32'h7FFF_FFFF;
    localparam logic [FLOW_W-1:0] FLOW_MIN = 32'h8000_0000;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // quarter-wave sine entry in q16, taylor series in q30
    function automatic logic [TVAL_W-1:0] qsin_entry(input int unsigned tb,
                                                     input int unsigned idx);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x    = (HALF_PI_Q30 * 64'(idx)) >> tb;
        x2   = (x * x) >> 30;
        sum  = x;
        term = ((x * x2) >> 30) / 64'd6;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + term;
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - term;
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + term;
        v    = (sum + 64'd8192) >> 14;
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return TVAL_W'(v);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fws_ram.sv
// generic ram, one write port, two registered read ports
// depends on fws_pkg for default sizes
`timescale 1ns / 1ps
`default_nettype none

module fws_ram
    import fws_pkg::*;
#(
    parameter int WIDTH = TVAL_W,
    parameter int DEPTH = (1 << TABLE_BITS_DEF) + 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

`default_nettype wire

### hw/rtl/fourier_waveform_synth_unit.sv
// Fourier-series flow waveform synthesizer: one phase item in, one flow item out.
// After reset the quarter-wave sine table is loaded into one dual-read table memory per
// harmonic; s_tready stays low until then. Afterwards the block takes one item per clock
// while it is not stalled, in registered steps: phase multiply, table read, coefficient
// multiply, three adder-tree stages, a scale multiply split into two partial products,
// their merge, rounding and clamping. The output register stalls the whole pipeline
// when m_tready is low while it holds a valid item.
// Depends on fws_pkg, fws_ram and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fourier_waveform_synth_unit
    import fws_pkg::*;
#(
    parameter int HARMONICS  = HARMONICS_DEF,
    parameter int PHASE_BITS = PHASE_BITS_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [SCALE_W-1:0] cfg_wr_data,   // flow_scale
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [PHASE_W-1:0] s_tdata,       // [15:0] phase
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [FLOW_W-1:0]  m_tdata,       // [31:0] flow_value
    output logic [0:0]         m_tuser        // [0] saturated
);

    localparam int Qtr  = 1 << TABLE_BITS;
    localparam int UW   = TABLE_BITS + 2;
    localparam int AW   = TABLE_BITS + 1;
    localparam int Sh   = PHASE_BITS - TABLE_BITS - 2;
    localparam int NGRP = (HARMONICS + GRP_SIZE - 1) / GRP_SIZE;
    localparam int NSTG = 9;

    logic               adv;
    logic               s_acc;
    logic [PHASE_BITS-1:0] phase_in;

    logic [SCALE_W-1:0] flow_scale_reg;
    logic [NSTG-1:0]    vld_reg;

    logic               fill_run_reg;
    logic [AW-1:0]      fill_idx_reg;
    logic               wr_en_reg;
    logic [AW-1:0]      wr_addr_reg;
    logic [TVAL_W-1:0]  wr_data_reg;
    logic [TVAL_W-1:0]  qtab [Qtr+1];

    logic [UW-1:0]              u_reg        [HARMONICS];
    logic [TVAL_W-1:0]          sin_tv       [HARMONICS];
    logic [TVAL_W-1:0]          cos_tv       [HARMONICS];
    logic                       sin_neg_reg  [HARMONICS];
    logic                       cos_neg_reg  [HARMONICS];
    logic signed [PROD_W-1:0]   sin_prod_reg [HARMONICS];
    logic signed [PROD_W-1:0]   cos_prod_reg [HARMONICS];
    logic signed [HSUM_W-1:0]   hsum_reg     [HARMONICS];
    logic signed [GSUM_W-1:0]   gsum_reg     [NGRP];

    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [PLO_W-1:0]           plo_reg;
    logic signed [PHI_W-1:0]    phi_reg;
    logic signed [SPROD_W-1:0]  sprod_reg;
    logic [SPROD_W-1:0]         rsum;
    logic signed [RND_W-1:0]    rnd_reg;

    logic                       in_rng;
    logic [FLOW_W-1:0]          flow_next;
    logic                       m_tvalid_reg;
    logic [FLOW_W-1:0]          m_tdata_reg;
    logic                       m_sat_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && !fill_run_reg && !wr_en_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign phase_in = PHASE_BITS'(s_tdata);

    // constant quarter-wave table, swept into the table memories after reset
    for (genvar t = 0; t <= Qtr; t++) begin : g_qtab
        assign qtab[t] = qsin_entry(TABLE_BITS, t);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_run_reg <= 1'b1;
            fill_idx_reg <= '0;
            wr_en_reg    <= 1'b0;
        end else begin
            wr_en_reg <= fill_run_reg;
            if (fill_run_reg) begin
                if (fill_idx_reg == AW'(Qtr)) begin
                    fill_run_reg <= 1'b0;
                end else begin
                    fill_idx_reg <= fill_idx_reg + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        wr_addr_reg <= fill_idx_reg;
        wr_data_reg <= qtab[fill_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flow_scale_reg <= SCALE_RESET;
            vld_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                flow_scale_reg <= cfg_wr_data;
            end
            if (adv) begin
                vld_reg      <= {vld_reg[NSTG-2:0], s_acc};
                m_tvalid_reg <= vld_reg[NSTG-1];
            end
        end
    end

    // per harmonic: phase position, table read, coefficient products, pair sum
    for (genvar g = 0; g < HARMONICS; g++) begin : g_harm
        logic [PHASE_BITS-1:0]     p;
        logic [UW-1:0]             u_next;
        logic [UW-1:0]             uc;
        logic [AW-1:0]             sa;
        logic [AW-1:0]             ca;
        logic signed [COEF_W-1:0]  sce;
        logic signed [COEF_W-1:0]  cce;
        logic signed [TVAL_W:0]    sv;
        logic signed [TVAL_W:0]    cv;

        assign p = PHASE_BITS'(phase_in * PHASE_BITS'(g + 1));

        if (Sh >= 0) begin : g_shr
            assign u_next = UW'(p >> Sh);
        end else begin : g_shl
            assign u_next = UW'(p) << (-Sh);
        end

        assign uc = u_reg[g] + UW'(Qtr);
        assign sa = u_reg[g][TABLE_BITS]
                  ? AW'(Qtr) - AW'(u_reg[g][TABLE_BITS-1:0])
                  : AW'(u_reg[g][TABLE_BITS-1:0]);
        assign ca = uc[TABLE_BITS]
                  ? AW'(Qtr) - AW'(uc[TABLE_BITS-1:0])
                  : AW'(uc[TABLE_BITS-1:0]);

        fws_ram #(
            .WIDTH (TVAL_W),
            .DEPTH (Qtr + 1)
        ) u_tab (
            .aclk    (aclk),
            .we      (wr_en_reg),
            .waddr   (wr_addr_reg),
            .wdata   (wr_data_reg),
            .re      (adv),
            .raddr_a (sa),
            .raddr_b (ca),
            .rdata_a (sin_tv[g]),
            .rdata_b (cos_tv[g])
        );

        assign sce = sin_neg_reg[g] ? -SIN_COEF[g] : SIN_COEF[g];
        assign cce = cos_neg_reg[g] ? -COS_COEF[g] : COS_COEF[g];
        assign sv  = $signed({1'b0, sin_tv[g]});
        assign cv  = $signed({1'b0, cos_tv[g]});

        always_ff @(posedge aclk) begin
            if (adv) begin
                u_reg[g]        <= u_next;
                sin_neg_reg[g]  <= u_reg[g][TABLE_BITS+1];
                cos_neg_reg[g]  <= uc[TABLE_BITS+1];
                sin_prod_reg[g] <= sce * sv;
                cos_prod_reg[g] <= cce * cv;
                hsum_reg[g]     <= HSUM_W'(sin_prod_reg[g]) + HSUM_W'(cos_prod_reg[g]);
            end
        end
    end

    // groups of up to four harmonic sums
    for (genvar gg = 0; gg < NGRP; gg++) begin : g_grp
        logic signed [GSUM_W-1:0] gsum_next;

        always_comb begin
            gsum_next = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (gg * GRP_SIZE + j < HARMONICS) begin
                    gsum_next = gsum_next + GSUM_W'(hsum_reg[gg * GRP_SIZE + j]);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                gsum_reg[gg] <= gsum_next;
            end
        end
    end

    always_comb begin
        acc_next = DC_Q32;
        for (int j = 0; j < NGRP; j++) begin
            acc_next = acc_next + ACC_W'(gsum_reg[j]);
        end
    end

    assign rsum   = sprod_reg + (sprod_reg[SPROD_W-1] ? RND_BIAS_NEG : RND_BIAS_POS);
    assign in_rng = (&rnd_reg[RND_W-1:FLOW_W-1]) || !(|rnd_reg[RND_W-1:FLOW_W-1]);

    always_comb begin
        if (in_rng) begin
            flow_next = rnd_reg[FLOW_W-1:0];
        end else if (rnd_reg[RND_W-1]) begin
            flow_next = FLOW_MIN;
        end else begin
            flow_next = FLOW_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg     <= acc_next;
            plo_reg     <= PLO_W'(acc_reg[ACC_LO_W-1:0]) * PLO_W'(flow_scale_reg);
            phi_reg     <= $signed(acc_reg[ACC_W-1:ACC_LO_W]) * $signed({1'b0, flow_scale_reg});
            sprod_reg   <= (SPROD_W'(phi_reg) <<< ACC_LO_W) + SPROD_W'(plo_reg);
            rnd_reg     <= rsum[SPROD_W-1:RND_SH];
            m_tdata_reg <= flow_next;
            m_sat_reg   <= !in_rng;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_sat_reg;

    `FWS_ASSERT(a_fill_no_items, aclk, aresetn, !wr_en_reg || (vld_reg == '0 && !m_tvalid_reg), "table load overlaps an item in flight")
    `FWS_ASSERT(a_sat_clamped, aclk, aresetn, !(m_tvalid_reg && m_sat_reg) || m_tdata_reg == FLOW_MAX || m_tdata_reg == FLOW_MIN, "saturated item not clamped")
    `FWS_ASSERT_NEXT(a_fill_ends, aclk, aresetn, wr_en_reg && wr_addr_reg == AW'(Qtr), !wr_en_reg && !fill_run_reg, "table load does not end after last entry")

endmodule

`default_nettype wire

### test/tb_top.sv
// self-checking bench for fourier_waveform_synth_unit: streams phase items in and checks
// every flow item against a predictor of the harmonic sum, scaling, rounding and clamping
// depends on fws_pkg and fourier_waveform_synth_unit
`timescale 1ns / 1ps

module tb_top;
    import fws_pkg::*;

    typedef struct packed {
        logic [FLOW_W-1:0] flow;
        logic              sat;
    } flow_item_t;

    class flow_scoreboard;
        int         quarter_sine [1025];
        longint     cos_coef [8];
        longint     sin_coef [8];
        longint     scale;
        flow_item_t pending_flows [$];
        int         errors;
        int         checked;
        int         sat_seen;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned sum;
            longint unsigned term;
            longint unsigned v;
            cos_coef = '{7798784, -1165885, -3050045, -1806172,
                         -2127299, -1270088, -524419, -1040056};
            sin_coef = '{9351987, 8500019, 3264348, 1804861,
                         1074790, -157876, 389415, 220987};
            scale    = 65536;
            errors   = 0;
            checked  = 0;
            sat_seen = 0;
            // quarter-wave sine in q16 from a q30 taylor series
            for (int i = 0; i <= 1024; i++) begin
                x    = (64'd1686629713 * longint'(i)) / 1024;
                x2   = (x * x) >> 30;
                sum  = x;
                term = x;
                for (int n = 1; n <= 6; n++) begin
                    term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
                v = (sum + 8192) >> 14;
                if (v > 65536) begin
                    v = 65536;
                end
                quarter_sine[i] = int'(v);
            end
        endfunction

        function int sine_at(int unsigned u);
            int unsigned q;
            int unsigned idx;
            int          v;
            u   = u & 32'hFFF;
            q   = u >> 10;
            idx = u & 32'h3FF;
            v   = q[0] ? quarter_sine[1024 - idx] : quarter_sine[idx];
            return q[1] ? -v : v;
        endfunction

        function flow_item_t synth_flow(logic [PHASE_W-1:0] ph);
            longint          acc;
            longint          prod;
            longint unsigned mag;
            longint unsigned r;
            int unsigned     p;
            int unsigned     u;
            flow_item_t      res;
            acc = 64'sd6828851 * 65536;
            for (int k = 1; k <= 8; k++) begin
                p   = (k * int'(ph)) & 32'hFFFF;
                u   = p >> 4;
                acc = acc + cos_coef[k-1] * longint'(sine_at(u + 1024));
                acc = acc + sin_coef[k-1] * longint'(sine_at(u));
            end
            prod    = acc * scale;
            mag     = (prod < 0) ? longint'(-prod) : prod;
            r       = (mag + 64'h8000_0000) >> 32;
            res.sat = 1'b0;
            if (prod < 0) begin
                if (r > 64'h8000_0000) begin
                    r       = 64'h8000_0000;
                    res.sat = 1'b1;
                end
                res.flow = FLOW_W'(-longint'(r));
            end else begin
                if (r > 64'h7FFF_FFFF) begin
                    r       = 64'h7FFF_FFFF;
                    res.sat = 1'b1;
                end
                res.flow = FLOW_W'(r);
            end
            return res;
        endfunction

        function void set_scale(logic [SCALE_W-1:0] s);
            scale = longint'(s);
        endfunction

        function void note_phase(logic [PHASE_W-1:0] ph);
            pending_flows.insert(pending_flows.size(), synth_flow(ph));
        endfunction

        function void check_flow(logic [FLOW_W-1:0] flow, logic sat);
            flow_item_t want;
            if (pending_flows.size() == 0) begin
                errors++;
                $display("%0t unexpected item: expected none, got flow %h sat %0b",
                         $time, flow, sat);
                return;
            end
            want = pending_flows.pop_front();
            checked++;
            if (sat) begin
                sat_seen++;
            end
            if (flow !== want.flow) begin
                errors++;
                $display("%0t flow_value mismatch: expected %h, got %h",
                         $time, want.flow, flow);
            end
            if (sat !== want.sat) begin
                errors++;
                $display("%0t saturated mismatch: expected %0b, got %0b",
                         $time, want.sat, sat);
            end
        endfunction

        function int pending();
            return pending_flows.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [SCALE_W-1:0] cfg_wr_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [PHASE_W-1:0] s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [FLOW_W-1:0]  m_tdata;
    logic [0:0]         m_tuser;

    flow_scoreboard sb;
    logic           no_gaps;
    int             scale_writes;

    fourier_waveform_synth_unit u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_phase(input logic [PHASE_W-1:0] ph);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = ph;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_phase(ph);
        @(negedge aclk);
    endtask

    task automatic drain_flows();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_scale(input logic [SCALE_W-1:0] s);
        drain_flows();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = s;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_scale(s);
        scale_writes++;
    endtask

    initial begin : flow_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            sb.check_flow(m_tdata, m_tuser[0]);
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [PHASE_W-1:0] edge_phases [16];
        logic [SCALE_W-1:0] round_scale;
        logic [PHASE_W-1:0] ph;
        edge_phases = '{16'h0000, 16'h0001, 16'h000F, 16'h0010, 16'h0FFF, 16'h1000,
                        16'h2000, 16'h3FFF, 16'h4000, 16'h7FFF, 16'h8000, 16'hC000,
                        16'hFFF0, 16'hFFFF, 16'h5555, 16'hAAAA};
        sb           = new();
        scale_writes = 0;
        no_gaps      = 1'b0;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset scale, then zero and full-range scale
        foreach (edge_phases[i]) send_phase(edge_phases[i]);
        write_scale('0);
        send_phase(16'h0000);
        send_phase(16'h4000);
        send_phase(16'hFFFF);
        send_phase(16'h8000);
        write_scale(20'hFFFFF);
        send_phase(16'h0000);
        send_phase(16'h1234);
        send_phase(16'hFFFF);
        send_phase(16'hC000);

        for (int rnd = 0; rnd < 5; rnd++) begin
            case (rnd)
                0:       round_scale = 20'd1;
                2:       round_scale = 20'd65536;
                4:       round_scale = 20'hFFFFF;
                default: round_scale = SCALE_W'($urandom_range(0, 20'hFFFFF));
            endcase
            write_scale(round_scale);
            for (int n = 0; n < 246; n++) begin
                if (n % 50 == 0) begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                if ($urandom_range(0, 7) == 0) begin
                    // land near a multiple of 16'h1000, a quadrant boundary of the fourth harmonic
                    ph = PHASE_W'($urandom_range(0, 15) * 4096 + $urandom_range(0, 31) - 16);
                end else begin
                    ph = PHASE_W'($urandom_range(0, 16'hFFFF));
                end
                send_phase(ph);
            end
        end
        no_gaps = 1'b0;
        drain_flows();
        repeat (20) @(negedge aclk);

        $display("checked %0d flow items over %0d scale writes, %0d saturated",
                 sb.checked, scale_writes, sb.sat_seen);
        $display("mismatches %0d, items still awaited %0d", sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS fourier_waveform_synth_unit");
        end else begin
            $display("FAIL fourier_waveform_synth_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("timeout with %0d items awaited", sb.pending());
        $display("FAIL fourier_waveform_synth_unit");
        $finish;
    end

endmodule

### fourier_waveform_synth_unit.f
+incdir+hw/rtl
hw/rtl/fws_pkg.sv
hw/rtl/fws_ram.sv
hw/rtl/fourier_waveform_synth_unit.sv
test/tb_top.sv
